>>> src/zpc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the zero-padded 2D convolution unit.
// Used by every module of the block but zpc_ram; depends on nothing else.
package zpc_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 18;
    localparam int PROD_W   = COEF_W + SAMPLE_W + 1;
    localparam int OUT_W    = 32;
    localparam int ROW_W    = 16;
    localparam int COL_W    = 11;
    localparam int CHAN_W   = 2;
    localparam int FRAC_W   = 16;

    localparam logic CMD_COEF   = 1'b0;
    localparam logic CMD_STREAM = 1'b1;

    localparam logic [11:0] RST_WIDTH    = 12'd640;
    localparam logic [15:0] RST_HEIGHT   = 16'd480;
    localparam logic [2:0]  RST_CHANNELS = 3'd3;

    typedef enum logic [1:0] {
        CFG_WIDTH    = 2'd0,
        CFG_HEIGHT   = 2'd1,
        CFG_CHANNELS = 2'd2
    } zpc_cfg_idx_t;

    typedef struct packed {
        logic              frame_end;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [CHAN_W-1:0] channel;
    } zpc_meta_t;

endpackage

>>> src/zpc_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module zpc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/zpc_front.sv
`timescale 1ns / 1ps
// Raster position tracking, line memories and the first pipeline stage.
// Depends on zpc_pkg and zpc_ram.
module zpc_front import zpc_pkg::*; #(
    parameter int KERNEL_RADIUS = 2,
    parameter int MAX_WIDTH     = 2048,
    parameter int MAX_CHANNELS  = 4,
    localparam int K   = 2 * KERNEL_RADIUS + 1,
    localparam int WW  = $clog2(MAX_WIDTH + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         restart,
    input  logic [WW-1:0]                eff_width,
    input  logic [15:0]                  eff_height,
    input  logic [2:0]                   eff_chans,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         cmd,
    input  logic [4:0]                   coef_index,
    input  logic signed [COEF_W-1:0]     coef_value,
    input  logic [SAMPLE_W-1:0]          sample,
    input  logic                         s1_go,
    output logic                         s1_valid,
    output logic                         s1_stream,
    output logic [4:0]                   s1_coef_index,
    output logic signed [COEF_W-1:0]     s1_coef_value,
    output logic [K-1:0][SAMPLE_W-1:0]   s1_column,
    output logic [K-1:0]                 s1_lmask,
    output logic                         s1_emit,
    output zpc_meta_t                    s1_meta
);

    localparam int CPW = $clog2(MAX_WIDTH + KERNEL_RADIUS);
    localparam int RPW = $clog2(65535 + KERNEL_RADIUS);
    localparam int SW  = $clog2(K);
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int AW  = CW + CHW;

    logic [RPW-1:0]    pos_row_reg, pos_row_next;
    logic [CPW-1:0]    pos_col_reg, pos_col_next;
    logic [CHAN_W-1:0] pos_ch_reg, pos_ch_next;
    logic [SW-1:0]     slot_reg, slot_next;

    logic              s1_valid_reg, s1_valid_next;
    logic              s1_stream_reg;
    logic [4:0]        s1_idx_reg;
    logic signed [COEF_W-1:0] s1_coef_reg;
    logic [SAMPLE_W-1:0] s1_sample_reg;
    logic [SW-1:0]     s1_slot_reg;
    logic [K-1:0]      s1_rmask_reg, rmask;
    logic [K-1:0]      s1_lmask_reg, lmask;
    logic              s1_emit_reg;
    zpc_meta_t         s1_meta_reg, meta;

    logic              accept, stream, in_row, in_col;
    logic              ch_last, col_last, row_last, emit;
    logic [CPW-1:0]    w_ext;
    logic [RPW-1:0]    h_ext;
    logic [AW-1:0]     addr;
    logic [K-1:0][SAMPLE_W-1:0] ram_q;

    assign in_ready = !s1_valid_reg || s1_go;
    assign accept   = in_valid && in_ready;
    assign stream   = cmd == CMD_STREAM;
    assign w_ext    = CPW'(eff_width);
    assign h_ext    = RPW'(eff_height);
    assign in_row   = pos_row_reg < h_ext;
    assign in_col   = pos_col_reg < w_ext;
    assign ch_last  = pos_ch_reg == CHAN_W'(eff_chans - 3'd1);
    assign col_last = pos_col_reg == w_ext + CPW'(KERNEL_RADIUS - 1);
    assign row_last = pos_row_reg == h_ext + RPW'(KERNEL_RADIUS - 1);
    assign emit     = (pos_row_reg >= RPW'(KERNEL_RADIUS))
                   && (pos_col_reg >= CPW'(KERNEL_RADIUS));
    assign addr     = {pos_col_reg[CW-1:0], pos_ch_reg[CHW-1:0]};

    // Row masks cover the vertical zero padding and the fill columns, the column mask the left padding.
    always_comb
    begin
        logic [RPW:0] rsum;
        logic [CPW:0] csum;
        for (int i = 0; i < K; i++)
        begin
            rsum     = {1'b0, pos_row_reg} + (RPW + 1)'(i);
            rmask[i] = (rsum >= (RPW + 1)'(2 * KERNEL_RADIUS))
                    && (rsum < {1'b0, h_ext} + (RPW + 1)'(2 * KERNEL_RADIUS))
                    && in_col;
            csum     = {1'b0, pos_col_reg} + (CPW + 1)'(i);
            lmask[i] = csum >= (CPW + 1)'(2 * KERNEL_RADIUS);
        end
        meta.frame_end = row_last && col_last && ch_last;
        meta.row       = ROW_W'(pos_row_reg - RPW'(KERNEL_RADIUS));
        meta.col       = COL_W'(pos_col_reg - CPW'(KERNEL_RADIUS));
        meta.channel   = pos_ch_reg;
    end

    always_comb
    begin
        pos_row_next = pos_row_reg;
        pos_col_next = pos_col_reg;
        pos_ch_next  = pos_ch_reg;
        slot_next    = slot_reg;
        if (restart)
        begin
            pos_row_next = '0;
            pos_col_next = '0;
            pos_ch_next  = '0;
            slot_next    = '0;
        end
        else if (accept && stream)
        begin
            if (!ch_last)
            begin
                pos_ch_next = pos_ch_reg + CHAN_W'(1);
            end
            else
            begin
                pos_ch_next = '0;
                if (!col_last)
                begin
                    pos_col_next = pos_col_reg + CPW'(1);
                end
                else
                begin
                    pos_col_next = '0;
                    if (row_last)
                    begin
                        pos_row_next = '0;
                        slot_next    = '0;
                    end
                    else
                    begin
                        pos_row_next = pos_row_reg + RPW'(1);
                        slot_next    = (slot_reg == SW'(K - 1)) ? '0 : slot_reg + SW'(1);
                    end
                end
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_row_reg  <= '0;
            pos_col_reg  <= '0;
            pos_ch_reg   <= '0;
            slot_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            pos_row_reg  <= pos_row_next;
            pos_col_reg  <= pos_col_next;
            pos_ch_reg   <= pos_ch_next;
            slot_reg     <= slot_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_stream_reg <= stream;
            s1_idx_reg    <= coef_index;
            s1_coef_reg   <= coef_value;
            s1_sample_reg <= sample;
            s1_slot_reg   <= slot_reg;
            s1_rmask_reg  <= rmask;
            s1_lmask_reg  <= lmask;
            s1_emit_reg   <= emit;
            s1_meta_reg   <= meta;
        end
    end

    // One line memory per kernel row slot; the row being streamed writes its slot.
    for (genvar s = 0; s < K; s++)
    begin : g_line
        zpc_ram #(
            .WIDTH (SAMPLE_W),
            .DEPTH (2 ** AW)
        ) u_line (
            .clk   (clk),
            .we    (accept && stream && in_row && in_col && (slot_reg == SW'(s))),
            .waddr (addr),
            .wdata (sample),
            .re    (accept),
            .raddr (addr),
            .rdata (ram_q[s])
        );
    end

    // Kernel row i of the window sits in slot (slot + i + 1) mod K; the last row
    // is the sample that arrived with this request.
    always_comb
    begin
        logic [SW:0] rs;
        for (int i = 0; i < K; i++)
        begin
            rs = {1'b0, s1_slot_reg} + (SW + 1)'(i + 1);
            if (rs >= (SW + 1)'(K))
            begin
                rs = rs - (SW + 1)'(K);
            end
            if (!s1_rmask_reg[i])
            begin
                s1_column[i] = '0;
            end
            else if (i == K - 1)
            begin
                s1_column[i] = s1_sample_reg;
            end
            else
            begin
                s1_column[i] = ram_q[rs[SW-1:0]];
            end
        end
    end

    assign s1_valid      = s1_valid_reg;
    assign s1_stream     = s1_stream_reg;
    assign s1_coef_index = s1_idx_reg;
    assign s1_coef_value = s1_coef_reg;
    assign s1_lmask      = s1_lmask_reg;
    assign s1_emit       = s1_emit_reg;
    assign s1_meta       = s1_meta_reg;

endmodule

>>> src/zpc_window.sv
`timescale 1ns / 1ps
// Coefficient store and per-channel sliding windows; second pipeline stage.
// Depends on zpc_pkg.
module zpc_window import zpc_pkg::*; #(
    parameter int KERNEL_RADIUS = 2,
    parameter int MAX_CHANNELS  = 4,
    localparam int K  = 2 * KERNEL_RADIUS + 1,
    localparam int KT = K * K
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s1_valid,
    output logic                           s1_go,
    input  logic                           s1_stream,
    input  logic [4:0]                     s1_coef_index,
    input  logic signed [COEF_W-1:0]       s1_coef_value,
    input  logic [K-1:0][SAMPLE_W-1:0]     s1_column,
    input  logic [K-1:0]                   s1_lmask,
    input  logic                           s1_emit,
    input  zpc_meta_t                      s1_meta,
    input  logic                           s2_go,
    output logic                           s2_valid,
    output logic [KT-1:0][SAMPLE_W-1:0]    s2_taps,
    output zpc_meta_t                      s2_meta,
    output logic [KT-1:0][COEF_W-1:0]      coefs
);

    logic [KT-1:0][COEF_W-1:0] coef_reg;
    logic [MAX_CHANNELS-1:0][K-1:0][K-1:0][SAMPLE_W-1:0] win_reg;
    logic [K-1:0][K-1:0][SAMPLE_W-1:0] sel, shifted;
    logic [KT-1:0][SAMPLE_W-1:0] taps;
    logic s2_valid_reg, s2_valid_next;
    logic [KT-1:0][SAMPLE_W-1:0] s2_taps_reg;
    zpc_meta_t s2_meta_reg;

    assign s1_go = s1_valid && (!s2_valid_reg || s2_go);

    always_comb
    begin
        sel = '0;
        for (int c = 0; c < MAX_CHANNELS; c++)
        begin
            if (s1_meta.channel == CHAN_W'(c))
            begin
                sel = win_reg[c];
            end
        end
        for (int i = 0; i < K; i++)
        begin
            for (int j = 0; j < K; j++)
            begin
                shifted[i][j] = (j == K - 1) ? s1_column[i] : sel[i][j + 1];
                taps[i * K + j] = s1_lmask[j] ? shifted[i][j] : '0;
            end
        end
    end

    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        if (s1_go)
        begin
            s2_valid_next = s1_stream && s1_emit;
        end
        else if (s2_go)
        begin
            s2_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            coef_reg     <= '0;
        end
        else
        begin
            s2_valid_reg <= s2_valid_next;
            for (int k = 0; k < KT; k++)
            begin
                if (s1_go && !s1_stream && (int'(s1_coef_index) == k))
                begin
                    coef_reg[k] <= s1_coef_value;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_stream)
        begin
            for (int c = 0; c < MAX_CHANNELS; c++)
            begin
                if (s1_meta.channel == CHAN_W'(c))
                begin
                    win_reg[c] <= shifted;
                end
            end
            s2_taps_reg <= taps;
            s2_meta_reg <= s1_meta;
        end
    end

    assign s2_valid = s2_valid_reg;
    assign s2_taps  = s2_taps_reg;
    assign s2_meta  = s2_meta_reg;
    assign coefs    = coef_reg;

endmodule

>>> src/zpc_mac.sv
`timescale 1ns / 1ps
// Multiply, adder tree, rounding toward zero and saturation; result register.
// Depends on zpc_pkg.
module zpc_mac import zpc_pkg::*; #(
    parameter int KERNEL_RADIUS = 2,
    localparam int K  = 2 * KERNEL_RADIUS + 1,
    localparam int KT = K * K
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s2_valid,
    output logic                         s2_go,
    input  logic [KT-1:0][SAMPLE_W-1:0]  s2_taps,
    input  zpc_meta_t                    s2_meta,
    input  logic [KT-1:0][COEF_W-1:0]    coefs,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [OUT_W-1:0]      filtered,
    output zpc_meta_t                    out_meta
);

    localparam int ROWS_W = PROD_W + $clog2(K);
    localparam int SUM_W  = PROD_W + $clog2(KT);
    localparam int QW     = SUM_W - FRAC_W;

    logic v3_reg, v4_reg, v5_reg, vo_reg;
    logic s3_go, s4_go, s5_go;
    zpc_meta_t m3_reg, m4_reg, m5_reg, mo_reg;
    logic signed [KT-1:0][PROD_W-1:0] prod_reg;
    logic signed [K-1:0][ROWS_W-1:0]  row_reg;
    logic signed [SUM_W-1:0]          total_reg;
    logic signed [OUT_W-1:0]          filt_reg;
    logic signed [K-1:0][ROWS_W-1:0]  rows;
    logic signed [SUM_W-1:0]          total;
    logic signed [OUT_W-1:0]          sat;

    assign s5_go = v5_reg && (!vo_reg || out_ready);
    assign s4_go = v4_reg && (!v5_reg || s5_go);
    assign s3_go = v3_reg && (!v4_reg || s4_go);
    assign s2_go = s2_valid && (!v3_reg || s3_go);

    // Elements of a packed array read as unsigned, so each one is sign extended
    // explicitly before it joins a wider sum.
    always_comb
    begin
        for (int i = 0; i < K; i++)
        begin
            rows[i] = '0;
            for (int j = 0; j < K; j++)
            begin
                rows[i] = rows[i] + ROWS_W'($signed(prod_reg[i * K + j]));
            end
        end
        total = '0;
        for (int i = 0; i < K; i++)
        begin
            total = total + SUM_W'($signed(row_reg[i]));
        end
    end

    // Divide by 2^16 toward zero: bias negative sums before the arithmetic shift.
    always_comb
    begin
        logic signed [SUM_W-1:0] biased;
        logic signed [QW-1:0]    q;
        logic signed [63:0]      q64;
        biased = total_reg + (total_reg[SUM_W-1] ? SUM_W'((1 << FRAC_W) - 1) : SUM_W'(0));
        q      = QW'(biased >>> FRAC_W);
        q64    = 64'(q);
        if (q64 > 64'sh7FFF_FFFF)
        begin
            sat = 32'sh7FFF_FFFF;
        end
        else if (q64 < -64'sh8000_0000)
        begin
            sat = 32'sh8000_0000;
        end
        else
        begin
            sat = OUT_W'(q64);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (s2_go)
                v3_reg <= 1'b1;
            else if (s3_go)
                v3_reg <= 1'b0;
            if (s3_go)
                v4_reg <= 1'b1;
            else if (s4_go)
                v4_reg <= 1'b0;
            if (s4_go)
                v5_reg <= 1'b1;
            else if (s5_go)
                v5_reg <= 1'b0;
            if (s5_go)
                vo_reg <= 1'b1;
            else if (out_ready)
                vo_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_go)
        begin
            for (int k = 0; k < KT; k++)
            begin
                prod_reg[k] <= $signed(coefs[k]) * $signed({1'b0, s2_taps[k]});
            end
            m3_reg <= s2_meta;
        end
        if (s3_go)
        begin
            row_reg <= rows;
            m4_reg  <= m3_reg;
        end
        if (s4_go)
        begin
            total_reg <= total;
            m5_reg    <= m4_reg;
        end
        if (s5_go)
        begin
            filt_reg <= sat;
            mo_reg   <= m5_reg;
        end
    end

    assign out_valid = vo_reg;
    assign filtered  = filt_reg;
    assign out_meta  = mo_reg;

endmodule

>>> src/zero_padded_2d_convolution_unit.sv
`timescale 1ns / 1ps
// Top level of the zero-padded 2D convolution unit: configuration registers
// and the pipeline. Depends on zpc_pkg, zpc_front, zpc_window and zpc_mac.
//
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------------------------
//  cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data
//  in      | in_valid/in_ready   | cmd, coef_index, coef_value, sample
//  out     | out_valid/out_ready | filtered, out_row, out_col, out_channel, frame_end
//
// One request is taken per clock; the pipeline is six registers deep from an
// accepted stream request to its result (line memory read, window, multiply,
// row sums, total, round and saturate). Each stage moves when the stage behind
// it is empty or moving, so empty slots absorb a stalled output and requests
// keep flowing until every stage holds a result. Reset clears the control state,
// the coefficients and the configuration (640 x 480, three channels); the line
// memories need no clearing pass since zero padding masks every unwritten entry.
module zero_padded_2d_convolution_unit import zpc_pkg::*; #(
    parameter int KERNEL_RADIUS = 2,
    parameter int MAX_WIDTH     = 2048,
    parameter int MAX_CHANNELS  = 4
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [1:0]               cfg_index,
    input  logic [15:0]              cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     cmd,
    input  logic [4:0]               coef_index,
    input  logic signed [COEF_W-1:0] coef_value,
    input  logic [SAMPLE_W-1:0]      sample,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [OUT_W-1:0]  filtered,
    output logic [ROW_W-1:0]         out_row,
    output logic [COL_W-1:0]         out_col,
    output logic [CHAN_W-1:0]        out_channel,
    output logic                     frame_end
);

    localparam int K  = 2 * KERNEL_RADIUS + 1;
    localparam int KT = K * K;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int EW = (WW > 12) ? WW : 12;

    logic [11:0] width_reg;
    logic [15:0] height_reg;
    logic [2:0]  chans_reg;
    logic        cfg_write, restart;
    logic [EW-1:0] w_wide;
    logic [WW-1:0] eff_width;
    logic [15:0]   eff_height;
    logic [2:0]    eff_chans;

    logic s1_valid, s1_go, s1_stream, s1_emit;
    logic [4:0] s1_coef_index;
    logic signed [COEF_W-1:0] s1_coef_value;
    logic [K-1:0][SAMPLE_W-1:0] s1_column;
    logic [K-1:0] s1_lmask;
    zpc_meta_t s1_meta, s2_meta, out_meta;
    logic s2_valid, s2_go;
    logic [KT-1:0][SAMPLE_W-1:0] s2_taps;
    logic [KT-1:0][COEF_W-1:0] coefs;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // A write to any known register restarts the raster at the frame origin.
    always_comb
    begin
        restart = 1'b0;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_WIDTH, CFG_HEIGHT, CFG_CHANNELS: restart = 1'b1;
                default:                             restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_WIDTH;
            height_reg <= RST_HEIGHT;
            chans_reg  <= RST_CHANNELS;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_WIDTH:    width_reg  <= cfg_data[11:0];
                CFG_HEIGHT:   height_reg <= cfg_data;
                CFG_CHANNELS: chans_reg  <= cfg_data[2:0];
                default:      ;
            endcase
        end
    end

    // Out-of-range settings are clamped into the supported range.
    always_comb
    begin
        w_wide = EW'(width_reg);
        if (w_wide == '0)
        begin
            w_wide = EW'(1);
        end
        else if (w_wide > EW'(MAX_WIDTH))
        begin
            w_wide = EW'(MAX_WIDTH);
        end
        eff_width  = WW'(w_wide);
        eff_height = (height_reg == '0) ? 16'd1 : height_reg;
        if (chans_reg == '0)
        begin
            eff_chans = 3'd1;
        end
        else if (chans_reg > 3'(MAX_CHANNELS))
        begin
            eff_chans = 3'(MAX_CHANNELS);
        end
        else
        begin
            eff_chans = chans_reg;
        end
    end

    zpc_front #(
        .KERNEL_RADIUS (KERNEL_RADIUS),
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_CHANNELS  (MAX_CHANNELS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .restart       (restart),
        .eff_width     (eff_width),
        .eff_height    (eff_height),
        .eff_chans     (eff_chans),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .coef_index    (coef_index),
        .coef_value    (coef_value),
        .sample        (sample),
        .s1_go         (s1_go),
        .s1_valid      (s1_valid),
        .s1_stream     (s1_stream),
        .s1_coef_index (s1_coef_index),
        .s1_coef_value (s1_coef_value),
        .s1_column     (s1_column),
        .s1_lmask      (s1_lmask),
        .s1_emit       (s1_emit),
        .s1_meta       (s1_meta)
    );

    zpc_window #(
        .KERNEL_RADIUS (KERNEL_RADIUS),
        .MAX_CHANNELS  (MAX_CHANNELS)
    ) u_window (
        .clk           (clk),
        .rst_n         (rst_n),
        .s1_valid      (s1_valid),
        .s1_go         (s1_go),
        .s1_stream     (s1_stream),
        .s1_coef_index (s1_coef_index),
        .s1_coef_value (s1_coef_value),
        .s1_column     (s1_column),
        .s1_lmask      (s1_lmask),
        .s1_emit       (s1_emit),
        .s1_meta       (s1_meta),
        .s2_go         (s2_go),
        .s2_valid      (s2_valid),
        .s2_taps       (s2_taps),
        .s2_meta       (s2_meta),
        .coefs         (coefs)
    );

    zpc_mac #(
        .KERNEL_RADIUS (KERNEL_RADIUS)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .s2_valid  (s2_valid),
        .s2_go     (s2_go),
        .s2_taps   (s2_taps),
        .s2_meta   (s2_meta),
        .coefs     (coefs),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .filtered  (filtered),
        .out_meta  (out_meta)
    );

    assign out_row     = out_meta.row;
    assign out_col     = out_meta.col;
    assign out_channel = out_meta.channel;
    assign frame_end   = out_meta.frame_end;

    // The input side can only be blocked when the whole pipeline is backed up.
    a_stall_from_output: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input blocked while output is not stalled");

    // The row and channel of every result lie inside the configured frame.
    a_result_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_row < eff_height) && (3'(out_channel) < eff_chans))
        else $error("result outside the frame");

    // The frame end marker sits on the bottom row, last channel.
    a_frame_end_place: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_end) |->
            (out_row == eff_height - 16'd1) && (3'(out_channel) == eff_chans - 3'd1))
        else $error("frame end marker on the wrong result");

endmodule

>>> tb/sv/zero_padded_2d_convolution_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the zero-padded 2D convolution unit.
// Depends on zpc_pkg and zero_padded_2d_convolution_unit; reads no files.
module zero_padded_2d_convolution_unit_tb;
    import zpc_pkg::*;

    localparam int RADIUS    = 2;
    localparam int KDIM      = 2 * RADIUS + 1;
    localparam int KTAPS     = KDIM * KDIM;
    localparam int MAXW      = 2048;
    localparam int MAXC      = 4;
    localparam int DRAIN_CYC = 12;
    localparam int CYCLE_CAP = 400000;
    // Index 3 addresses no register; writes to it must be ignored.
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic signed [OUT_W-1:0] filtered;
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic [CHAN_W-1:0]       channel;
        logic                    frame_end;
    } pixel_result_t;

    logic clk;
    logic rst_n;
    logic cfg_valid, cfg_ready;
    logic [1:0] cfg_index;
    logic [15:0] cfg_data;
    logic in_valid, in_ready;
    logic cmd;
    logic [4:0] coef_index;
    logic signed [COEF_W-1:0] coef_value;
    logic [SAMPLE_W-1:0] sample;
    logic out_valid, out_ready;
    logic signed [OUT_W-1:0] filtered;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic [CHAN_W-1:0] out_channel;
    logic frame_end;

    zero_padded_2d_convolution_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .coef_index(coef_index), .coef_value(coef_value), .sample(sample),
        .out_valid(out_valid), .out_ready(out_ready),
        .filtered(filtered), .out_row(out_row), .out_col(out_col),
        .out_channel(out_channel), .frame_end(frame_end)
    );

    // Shadow copy of the block: kernel, recent rows, raster position and registers.
    int                kernel_taps [KTAPS];
    logic [15:0]       row_buffer [KDIM][MAXW][MAXC];
    int unsigned       cur_row, cur_col, cur_chan;
    logic [11:0]       reg_width;
    logic [15:0]       reg_height;
    logic [2:0]        reg_chans;

    pixel_result_t     pending_pixels [$];
    int                error_count;
    int                items_sent;
    int                pixels_checked;
    int                frames_seen;
    int                cycle_count;
    int                burst_left;
    int                stall_mode;

    always #5 clk = ~clk;

    // The cycle counter doubles as a watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP)
        begin
            $display("Timeout after %0d cycles with %0d results pending",
                     cycle_count, pending_pixels.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // The output side switches at random between stall patterns: always ready,
    // randomly ready, bursty, or mostly stalled.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_mode <= 0;
        end
        else
        begin
            if (cycle_count % 256 == 0)
                stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 9) < 7);
                2: out_ready <= (cycle_count % 8 < 3);
                default: out_ready <= (cycle_count % 16 == 0);
            endcase
        end
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        error_count++;
    endtask

    // Every result taken from the block is compared with the oldest expected pixel.
    always @(posedge clk)
    begin
        pixel_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pixels.size() == 0)
                report_mismatch($sformatf("unexpected result row %0d col %0d ch %0d",
                                          out_row, out_col, out_channel));
            else
            begin
                want = pending_pixels.pop_front();
                pixels_checked++;
                if (frame_end)
                    frames_seen++;
                if (filtered !== want.filtered || out_row !== want.row ||
                    out_col !== want.col || out_channel !== want.channel ||
                    frame_end !== want.frame_end)
                    report_mismatch($sformatf(
                        "got %0d r%0d c%0d ch%0d fe%0b, want %0d r%0d c%0d ch%0d fe%0b",
                        filtered, out_row, out_col, out_channel, frame_end,
                        want.filtered, want.row, want.col, want.channel,
                        want.frame_end));
            end
        end
    end

    function automatic int unsigned active_width();
        if (reg_width < 1) return 1;
        if (reg_width > MAXW) return MAXW;
        return reg_width;
    endfunction

    function automatic int unsigned active_height();
        return (reg_height < 1) ? 1 : reg_height;
    endfunction

    function automatic int unsigned active_chans();
        if (reg_chans < 1) return 1;
        if (reg_chans > MAXC) return MAXC;
        return reg_chans;
    endfunction

    // Stream requests per frame, padding rows and columns included.
    function automatic int frame_requests();
        return (active_height() + RADIUS) * (active_width() + RADIUS) * active_chans();
    endfunction

    // Stores the sample when it lies in the frame, then emits the pixel whose
    // window has just been completed, if any, and advances the raster position.
    function automatic void convolve_sample(input logic [15:0] smp);
        int unsigned w, h, nc, orow, ocol;
        longint acc, quot;
        int ni, nj;
        pixel_result_t px;
        w  = active_width();
        h  = active_height();
        nc = active_chans();
        if (cur_row < h && cur_col < w && cur_chan < nc)
            row_buffer[cur_row % KDIM][cur_col][cur_chan] = smp;
        if (cur_row >= RADIUS && cur_col >= RADIUS && cur_chan < nc &&
            cur_row - RADIUS < h && cur_col - RADIUS < w)
        begin
            orow = cur_row - RADIUS;
            ocol = cur_col - RADIUS;
            acc  = 0;
            for (int ik = 0; ik < KDIM; ik++)
            begin
                ni = int'(orow) + ik - RADIUS;
                if (ni < 0 || ni >= int'(h))
                    continue;
                for (int jk = 0; jk < KDIM; jk++)
                begin
                    nj = int'(ocol) + jk - RADIUS;
                    if (nj < 0 || nj >= int'(w))
                        continue;
                    acc += longint'(kernel_taps[ik * KDIM + jk]) *
                           longint'(row_buffer[ni % KDIM][nj][cur_chan]);
                end
            end
            // Signed division truncates toward zero, as the hardware must.
            quot = acc / 65536;
            if (quot > 64'sd2147483647)
                quot = 64'sd2147483647;
            if (quot < -64'sd2147483648)
                quot = -64'sd2147483648;
            px.filtered  = quot[31:0];
            px.row       = orow[ROW_W-1:0];
            px.col       = ocol[COL_W-1:0];
            px.channel   = cur_chan[CHAN_W-1:0];
            px.frame_end = (cur_row == h + RADIUS - 1 && cur_col == w + RADIUS - 1 &&
                            cur_chan == nc - 1);
            pending_pixels.push_back(px);
        end
        cur_chan++;
        if (cur_chan >= nc)
        begin
            cur_chan = 0;
            cur_col++;
            if (cur_col >= w + RADIUS)
            begin
                cur_col = 0;
                cur_row++;
                if (cur_row >= h + RADIUS)
                    cur_row = 0;
            end
        end
    endfunction

    // Sends one request; the sender runs in bursts with random gaps between them.
    task automatic send_item(input logic c, input logic [4:0] idx,
                             input logic signed [COEF_W-1:0] val, input logic [15:0] smp);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        burst_left--;
        in_valid   <= 1'b1;
        cmd        <= c;
        coef_index <= idx;
        coef_value <= val;
        sample     <= smp;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
        if (c == CMD_COEF)
        begin
            // Taps past the end of the kernel are dropped.
            if (idx < KTAPS)
                kernel_taps[idx] = val;
        end
        else
            convolve_sample(smp);
    endtask

    task automatic send_stream(input int count);
        for (int i = 0; i < count; i++)
            send_item(CMD_STREAM, 5'($urandom), 18'($urandom), 16'($urandom));
    endtask

    // Lowers valid and waits until every expected pixel has come out, then lets
    // the pipeline settle so a trailing coefficient write cannot still be in flight.
    task automatic drain_pipeline();
        if (in_valid)
            in_valid <= 1'b0;
        @(posedge clk);
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    // Register writes happen only with the pipeline empty. Any write to a real
    // register restarts the raster at the origin.
    task automatic write_register(input logic [1:0] idx, input logic [15:0] data);
        drain_pipeline();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_WIDTH:    reg_width  = data[11:0];
            CFG_HEIGHT:   reg_height = data;
            CFG_CHANNELS: reg_chans  = data[2:0];
            default:      return;
        endcase
        cur_row  = 0;
        cur_col  = 0;
        cur_chan = 0;
    endtask

    task automatic set_frame(input int w, input int h, input int c);
        write_register(CFG_WIDTH, {4'($urandom), 12'(w)});
        write_register(CFG_HEIGHT, 16'(h));
        write_register(CFG_CHANNELS, {13'($urandom), 3'(c)});
    endtask

    task automatic load_random_kernel();
        for (int t = 0; t < KTAPS; t++)
            send_item(CMD_COEF, 5'(t), 18'($urandom), 16'($urandom));
    endtask

    // Coefficient extremes, writes past the kernel end, and a small frame with
    // full-scale and zero samples, so the largest positive tap reaches the output.
    task automatic test_directed();
        set_frame(3, 2, 2);
        send_item(CMD_COEF, 5'd12, 18'sd131071, 16'hFFFF);
        send_item(CMD_COEF, 5'd0, -18'sd131072, 16'h0000);
        send_item(CMD_COEF, 5'd24, 18'sd65536, 16'h1234);
        send_item(CMD_COEF, 5'd25, 18'sd777, 16'h0000);
        send_item(CMD_COEF, 5'd31, -18'sd1, 16'hFFFF);
        for (int i = 0; i < frame_requests(); i++)
            send_item(CMD_STREAM, 5'd0, 18'sd0, (i % 3 == 0) ? 16'h0000 : 16'hFFFF);
    endtask

    // Register extremes: clamping of zero and oversized values, the unused
    // register index, a long single-column frame and a partial wide one.
    task automatic test_register_extremes();
        load_random_kernel();
        set_frame(0, 0, 0);
        send_stream(2 * frame_requests());
        set_frame(1, 65535, 7);
        send_stream(300);
        write_register(CFG_UNUSED, 16'($urandom));
        send_stream(40);
        set_frame(200, 1, 1);
        send_stream(2 * (200 + RADIUS) + 25);
    endtask

    // Random small frames, mostly whole frames back to back, often with new kernels
    // in between, plus cut-off frames and stray coefficient writes mid-stream.
    task automatic test_random_frames(input int budget);
        int start, frames, cut;
        start = items_sent;
        while (items_sent - start < budget)
        begin
            set_frame($urandom_range(1, 8), $urandom_range(1, 6), $urandom_range(0, 7));
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++)
            begin
                if ($urandom_range(0, 1) == 0)
                    load_random_kernel();
                cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, frame_requests())
                                                  : frame_requests();
                for (int i = 0; i < cut; i++)
                begin
                    if ($urandom_range(0, 19) == 0)
                        send_item(CMD_COEF, 5'($urandom), 18'($urandom), 16'($urandom));
                    send_item(CMD_STREAM, 5'($urandom), 18'($urandom), 16'($urandom));
                end
                if (cut != frame_requests())
                    break;
            end
            // Sometimes hold the sender back until the output side has caught up.
            if ($urandom_range(0, 4) == 0)
                drain_pipeline();
        end
    endtask

    initial
    begin
        clk        = 1'b0;
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_WIDTH;
        cfg_data   = '0;
        in_valid   = 1'b0;
        cmd        = CMD_STREAM;
        coef_index = '0;
        coef_value = '0;
        sample     = '0;
        error_count    = 0;
        items_sent     = 0;
        pixels_checked = 0;
        frames_seen    = 0;
        cycle_count    = 0;
        burst_left     = 0;
        for (int t = 0; t < KTAPS; t++)
            kernel_taps[t] = 0;
        cur_row    = 0;
        cur_col    = 0;
        cur_chan   = 0;
        reg_width  = RST_WIDTH;
        reg_height = RST_HEIGHT;
        reg_chans  = RST_CHANNELS;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_register_extremes();
        test_random_frames(800);

        drain_pipeline();
        repeat (20) @(posedge clk);
        if (pending_pixels.size() != 0)
            report_mismatch($sformatf("%0d expected pixels never came out",
                                      pending_pixels.size()));
        $display("Sent %0d requests, checked %0d filtered pixels over %0d complete frames,",
                 items_sent, pixels_checked, frames_seen);
        $display("including clamped registers and a wide line; %0d mismatches.",
                 error_count);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
